[rtl/core/vcsd_pkg.sv]
// vcsd_pkg: beat types and result codes for the voxel column span decoder
// no dependencies
`timescale 1ns / 1ps

package vcsd_pkg;

  localparam logic KIND_VOXEL = 1'b0;
  localparam logic KIND_END   = 1'b1;

  localparam logic [7:0] COLUMN_HEIGHT_RESET = 8'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       column_start;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] depth;
    logic [7:0] color;
    logic [7:0] normal;
  } out_beat_t;

  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } vcsd_res_t;

endpackage

[rtl/core/vcsd_decode.sv]
// vcsd_decode: span phase tracking, depth counting and result forming per byte
// depends on vcsd_pkg
`timescale 1ns / 1ps

module vcsd_decode
  import vcsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       take,
  input  in_beat_t   beat,
  output vcsd_res_t  res
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SKIP,
    PH_COUNT,
    PH_COLOR,
    PH_NORMAL,
    PH_DUP,
    PH_DONE
  } phase_t;

  phase_t     phase, phase_next;
  logic [8:0] depth_pos, depth_pos_next;
  logic [7:0] pairs_left, pairs_left_next;
  logic [7:0] held_color, held_color_next;
  logic [7:0] column_height;

  phase_t     ph;
  logic [8:0] dp;
  logic [7:0] pl;
  logic [8:0] skip_sum;
  logic [8:0] depth_inc;
  logic [8:0] height_ext;

  always_comb begin
    ph         = beat.column_start ? PH_SKIP : phase;
    dp         = beat.column_start ? 9'd0 : depth_pos;
    pl         = beat.column_start ? 8'd0 : pairs_left;
    height_ext = {1'b0, column_height};
    skip_sum   = dp + {1'b0, beat.data_byte};
    depth_inc  = dp + 9'd1;

    phase_next      = ph;
    depth_pos_next  = dp;
    pairs_left_next = pl;
    held_color_next = held_color;
    res             = '0;

    unique case (ph)
      PH_SKIP: begin
        depth_pos_next = skip_sum;
        if (skip_sum >= height_ext || beat.last_byte) begin
          res.valid      = 1'b1;
          res.beat.kind  = KIND_END;
          phase_next     = PH_DONE;
        end else begin
          phase_next = PH_COUNT;
        end
      end
      PH_COUNT: begin
        pairs_left_next = beat.data_byte;
        if (beat.last_byte) begin
          res.valid     = 1'b1;
          res.beat.kind = KIND_END;
          phase_next    = PH_DONE;
        end else begin
          phase_next = (beat.data_byte == 8'd0) ? PH_DUP : PH_COLOR;
        end
      end
      PH_COLOR: begin
        held_color_next = beat.data_byte;
        if (beat.last_byte) begin
          res.valid     = 1'b1;
          res.beat.kind = KIND_END;
          phase_next    = PH_DONE;
        end else begin
          phase_next = PH_NORMAL;
        end
      end
      PH_NORMAL: begin
        res.valid       = 1'b1;
        res.beat.kind   = KIND_VOXEL;
        res.beat.depth  = dp[7:0];
        res.beat.color  = held_color;
        res.beat.normal = beat.data_byte;
        depth_pos_next  = depth_inc;
        pairs_left_next = pl - 8'd1;
        if (depth_inc >= height_ext || beat.last_byte) begin
          phase_next = PH_DONE;
        end else begin
          phase_next = (pl == 8'd1) ? PH_DUP : PH_COLOR;
        end
      end
      PH_DUP: begin
        if (beat.last_byte) begin
          res.valid     = 1'b1;
          res.beat.kind = KIND_END;
          phase_next    = PH_DONE;
        end else begin
          phase_next = PH_SKIP;
        end
      end
      PH_IDLE, PH_DONE: begin
        phase_next = ph;
      end
      default: begin
        phase_next = ph;
      end
    endcase

    if (!take) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      depth_pos     <= 9'd0;
      pairs_left    <= 8'd0;
      column_height <= COLUMN_HEIGHT_RESET;
    end else begin
      if (cfg_wr_en) begin
        column_height <= cfg_wr_data;
      end
      if (take) begin
        phase      <= phase_next;
        depth_pos  <= depth_pos_next;
        pairs_left <= pairs_left_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_color <= held_color_next;
    end
  end

endmodule

[rtl/core/vcsd_out_buf.sv]
// vcsd_out_buf: result register with a skid stage in front of the output channel
// depends on vcsd_pkg
`timescale 1ns / 1ps

module vcsd_out_buf
  import vcsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  vcsd_res_t res,
  output logic      ready,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_beat
);

  logic      skid_valid;
  out_beat_t skid_beat;

  assign ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res.valid;
      end
    end else if (res.valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_beat <= skid_valid ? skid_beat : res.beat;
    end else if (res.valid) begin
      skid_beat <= res.beat;
    end
  end

endmodule

[rtl/core/voxel_column_span_decoder.sv]
// voxel column span decoder: one stream byte accepted per cycle while in_ready is high, zero or one result per byte
// a result is registered in out_beat, or held in the skid register while the output is stalled
// throughput: one byte per cycle while in_ready is high; the skid stage keeps input open for one stalled result
// reset: synchronous, clears phase, depth, pair count and buffers; column_height returns to 1
// depends on vcsd_pkg, vcsd_decode, vcsd_out_buf
`timescale 1ns / 1ps

module voxel_column_span_decoder
  import vcsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_beat_t   in_beat,
  output logic       out_valid,
  input  logic       out_ready,
  output out_beat_t  out_beat
);

  vcsd_res_t res;
  logic      take;

  assign take = in_valid && in_ready;

  vcsd_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .take        (take),
    .beat        (in_beat),
    .res         (res)
  );

  vcsd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .ready     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

endmodule

[rtl/core/vcsd_checker.sv]
// vcsd_checker: port level properties of the voxel column span decoder, bound to the top
// depends on vcsd_pkg and voxel_column_span_decoder
`timescale 1ns / 1ps

module vcsd_checker
  import vcsd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input out_beat_t  out_beat
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_beat))
    else $error("stalled output beat changed");

  a_end_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_beat.kind == KIND_END |->
      out_beat.depth == 8'd0 && out_beat.color == 8'd0 && out_beat.normal == 8'd0)
    else $error("end beat carries voxel fields");

  a_voxel_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_beat.kind == KIND_VOXEL |-> out_beat.depth != 8'hFF)
    else $error("voxel depth out of range");

  a_stall_backed: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending output");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind voxel_column_span_decoder vcsd_checker u_vcsd_checker (.*);
